@@ src/lkv_pkg.sv @@
`default_nettype none

package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CAP_W = 5;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CSR_DATA_W = 8;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_RESP   = 4'b1000
   } lkv_state_type;

   typedef struct packed {
      logic start;
      logic commit;
   } lkv_cmd_type;

   typedef struct packed {
      logic scan_done;
   } lkv_status_type;

endpackage

`default_nettype wire

@@ src/lkv_ctrl.sv @@
`default_nettype none

module lkv_ctrl
   import lkv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output lkv_cmd_type         cmd,
   input  wire lkv_status_type status
);

   lkv_state_type state_ff;
   lkv_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/lkv_datapath.sv @@
`default_nettype none

module lkv_datapath
   import lkv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lkv_cmd_type       cmd,
   output lkv_status_type         status,
   input  wire logic              req_op,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire logic              csr_wr,
   input  wire logic [CAP_W-1:0]  csr_cap,
   output logic                   rsp_found,
   output logic [VAL_W-1:0]       rsp_read_value,
   output logic                   rsp_evicted
);

   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [VAL_W-1:0] value_mem [ENTRIES];

   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [RANK_W-1:0] rank_ff [ENTRIES];
   logic [RANK_W-1:0] rank_in [ENTRIES];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic [KEY_W-1:0]  key_rd_ff;
   logic [VAL_W-1:0]  value_rd_ff;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              scan_active_ff;
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;

   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [VAL_W-1:0]  hit_value_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              vict_found_ff;
   logic [IDX_W-1:0]  vict_idx_ff;
   logic [RANK_W-1:0] vict_rank_ff;

   logic              is_put;
   logic              insert;
   logic              evict;
   logic [CNT_W-1:0]  eff_cap;
   logic [IDX_W-1:0]  slot_idx;
   logic [IDX_W-1:0]  wr_addr;
   logic              mem_we;
   logic [RANK_W-1:0] hit_rank;
   logic              cmp_valid;
   logic [RANK_W-1:0] cmp_rank;

   assign status.scan_done = cmp_vld_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1));

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if ({{(32-CAP_W){1'b0}}, cap_ff} > 32'(ENTRIES)) begin
         eff_cap = CNT_W'(ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign is_put = (op_ff == OP_PUT);
   assign insert = !hit_ff && is_put;
   assign evict = insert && (count_ff >= eff_cap) && (count_ff != '0);
   assign slot_idx = (evict && (!free_found_ff || (vict_idx_ff < free_idx_ff))) ?
                     vict_idx_ff : free_idx_ff;
   assign wr_addr = hit_ff ? hit_idx_ff : slot_idx;
   assign mem_we = cmd.commit && is_put;
   assign hit_rank = rank_ff[hit_idx_ff];
   assign cmp_valid = valid_ff[cmp_idx_ff];
   assign cmp_rank = rank_ff[cmp_idx_ff];

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int j = 0; j < ENTRIES; j++) begin
         rank_in[j] = rank_ff[j];
      end
      if (cmd.commit) begin
         if (hit_ff) begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (valid_ff[j] && (rank_ff[j] < hit_rank)) begin
                  rank_in[j] = rank_ff[j] + RANK_W'(1);
               end
            end
            rank_in[hit_idx_ff] = '0;
         end else if (insert) begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (valid_ff[j] && !(evict && (IDX_W'(j) == vict_idx_ff))) begin
                  rank_in[j] = rank_ff[j] + RANK_W'(1);
               end
            end
            if (evict) begin
               valid_in[vict_idx_ff] = 1'b0;
               rank_in[vict_idx_ff] = '0;
            end
            valid_in[slot_idx] = 1'b1;
            rank_in[slot_idx] = '0;
            count_in = count_ff - CNT_W'(evict) + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         valid_ff <= '0;
         count_ff <= '0;
         scan_active_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         scan_idx_ff <= '0;
         for (int j = 0; j < ENTRIES; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         if (csr_wr) begin
            cap_ff <= csr_cap;
         end
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int j = 0; j < ENTRIES; j++) begin
            rank_ff[j] <= rank_in[j];
         end
         cmp_vld_ff <= scan_active_ff;
         if (cmd.start) begin
            scan_active_ff <= 1'b1;
            scan_idx_ff <= '0;
         end else if (scan_active_ff) begin
            if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
               scan_active_ff <= 1'b0;
            end else begin
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr] <= key_ff;
         value_mem[wr_addr] <= value_ff;
      end
      key_rd_ff <= key_mem[scan_idx_ff];
      value_rd_ff <= value_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_idx_ff;
      if (cmd.start) begin
         op_ff <= req_op;
         key_ff <= req_key;
         value_ff <= req_value;
         hit_ff <= 1'b0;
         free_found_ff <= 1'b0;
         vict_found_ff <= 1'b0;
         hit_idx_ff <= '0;
         free_idx_ff <= '0;
         vict_idx_ff <= '0;
         vict_rank_ff <= '0;
      end else if (cmp_vld_ff) begin
         if (cmp_valid && (key_rd_ff == key_ff) && !hit_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= cmp_idx_ff;
            hit_value_ff <= value_rd_ff;
         end
         if (!cmp_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end
         if (cmp_valid && (!vict_found_ff || (cmp_rank > vict_rank_ff))) begin
            vict_found_ff <= 1'b1;
            vict_idx_ff <= cmp_idx_ff;
            vict_rank_ff <= cmp_rank;
         end
      end
      if (cmd.commit) begin
         rsp_found <= hit_ff;
         rsp_read_value <= (hit_ff && !is_put) ? hit_value_ff : '0;
         rsp_evicted <= evict;
      end
   end

endmodule

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// The request channel carries one get or put per transfer: req_tuser is the
// operation and req_tdata holds the key and the value to store. Each request
// gives exactly one response transfer with the found and evicted flags in
// rsp_tuser and the value read by a get hit in rsp_tdata (zero otherwise).
// The capacity register is written through the csr channel, which is always
// ready; it should only be written while no request is in progress.
// One request is handled at a time. After a request transfer the block reads
// the key and value memories one entry per cycle and compares each entry on
// the registered read data; once all entries are compared, the commit state
// applies the update, and the response is offered on the cycle after that.
// The time a request occupies the block is set mainly by the memory scan.
// While the receiver holds rsp_tready low the response stays valid and
// unchanged, and req_tready stays low until the response is taken.
// Reset clears all entries and the recency order and sets the capacity to 16.
`default_nettype none

module lru_key_value_cache
   import lkv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,  // lookup_key, store_value
   input  wire logic [0:0]            req_tuser,  // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,  // read_value
   output logic [1:0]                 rsp_tuser,  // found, evicted
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_DATA_W-1:0] csr_data    // capacity_in_use
);

   lkv_cmd_type    cmd;
   lkv_status_type status;
   logic           found;
   logic           evicted;

   assign csr_ready = 1'b1;

   lkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lkv_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_tuser[0]),
      .req_key        (req_tdata[KEY_W-1:0]),
      .req_value      (req_tdata[KEY_W+VAL_W-1:KEY_W]),
      .csr_wr         (csr_valid && csr_ready),
      .csr_cap        (csr_data[CAP_W-1:0]),
      .rsp_found      (found),
      .rsp_read_value (rsp_tdata),
      .rsp_evicted    (evicted)
   );

   assign rsp_tuser = {evicted, found};

endmodule

`default_nettype wire

@@ src/lkv_checker.sv @@
`default_nettype none

module lkv_checker
   import lkv_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [31:0]           rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // A stalled response keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Only one request is in progress at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("request accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while a response is pending");

   // An eviction only happens on a miss.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && (rsp_tdata == '0))
      else $error("eviction reported together with a hit");

   // A nonzero value is only returned for a key that was found.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata != '0) |-> rsp_tuser[0])
      else $error("value returned on a miss");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ test/testbench.sv @@
module testbench;
   import lkv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int POOL_SIZE = 20;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value;
      logic             evicted;
   } cache_resp_type;

   typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] data;
      logic             typed;
      cache_resp_type   resp;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic                  cache_valid [ENTRIES] = '{default: 1'b0};
   logic [KEY_W-1:0]      cache_key [ENTRIES];
   logic [VAL_W-1:0]      cache_value [ENTRIES];
   logic [RANK_W-1:0]     cache_rank [ENTRIES] = '{default: '0};
   logic [CNT_W-1:0]      cache_count = '0;
   logic [CAP_W-1:0]      cache_capacity = CAP_RESET;

   cache_resp_type        pending_rsp [$];
   logic                  typed_check = 1'b0;
   cache_resp_type        typed_rsp = '0;
   int                    mismatches = 0;
   int                    responses_seen = 0;
   int                    idle_cycles = 0;

   row_type directed_rows [25] = '{
      '{ROW_REQUEST,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{ROW_REQUEST,  OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
        '{1'b1, 32'h7FFF_FFFF, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 1'b0}},
      '{ROW_REQUEST,  OP_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b0}},
      '{ROW_REQUEST,  OP_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
      '{ROW_CAPACITY, OP_GET, 32'h0000_0000, 32'h0000_0002, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0005, 32'h0000_0005, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0006, 32'h0000_0006, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ROW_CAPACITY, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0007, 32'h0000_0007, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0008, 32'h0000_0008, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, '0},
      '{ROW_CAPACITY, OP_GET, 32'h0000_0000, 32'h0000_00FF, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_0009, 32'h0000_0009, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h0000_000A, 32'h0000_000A, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h0000_0008, 32'h0000_0000, 1'b0, '0},
      '{ROW_CAPACITY, OP_GET, 32'h0000_0000, 32'h0000_0010, 1'b0, '0},
      '{ROW_REQUEST,  OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_REQUEST,  OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, '0}
   };

   lru_key_value_cache i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void lru_access(input logic cmd, input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] data,
                                      output cache_resp_type resp);
      int hit;
      int victim;
      int slot;
      int limit;
      logic [RANK_W-1:0] old_rank;
      resp = '0;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && cache_valid[i] && cache_key[i] == key) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         resp.found = 1'b1;
         if (cmd == OP_GET) begin
            resp.value = cache_value[hit];
         end else begin
            cache_value[hit] = data;
         end
         old_rank = cache_rank[hit];
         for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i] && cache_rank[i] < old_rank) begin
               cache_rank[i] = cache_rank[i] + 1'b1;
            end
         end
         cache_rank[hit] = '0;
      end else if (cmd == OP_PUT) begin
         limit = (cache_capacity == 0) ? 1 : int'(cache_capacity);
         if (limit > ENTRIES) begin
            limit = ENTRIES;
         end
         if (int'(cache_count) >= limit && cache_count > 0) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim])) begin
                  victim = i;
               end
            end
            if (victim >= 0) begin
               cache_valid[victim] = 1'b0;
               cache_rank[victim] = '0;
               cache_count = cache_count - 1'b1;
               resp.evicted = 1'b1;
            end
         end
         slot = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !cache_valid[i]) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (cache_valid[i]) begin
                  cache_rank[i] = cache_rank[i] + 1'b1;
               end
            end
            cache_valid[slot] = 1'b1;
            cache_key[slot] = key;
            cache_value[slot] = data;
            cache_rank[slot] = '0;
            cache_count = cache_count + 1'b1;
         end
      end
   endfunction

   always @(posedge clock) begin : monitor
      cache_resp_type predicted;
      cache_resp_type oldest;
      cache_resp_type actual;
      logic           moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            cache_capacity = csr_data[CAP_W-1:0];
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            lru_access(req_tuser[0], req_tdata[31:0], req_tdata[63:32], predicted);
            pending_rsp.push_back(typed_check ? typed_rsp : predicted);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            actual.found = rsp_tuser[0];
            actual.value = rsp_tdata;
            actual.evicted = rsp_tuser[1];
            responses_seen++;
            moved = 1'b1;
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response, actual found %0b value %h evicted %0b",
                        $time, actual.found, actual.value, actual.evicted);
               mismatches++;
            end else begin
               oldest = pending_rsp.pop_front();
               if (actual.found !== oldest.found) begin
                  $display("%0t: found mismatch, expected %0b, actual %0b",
                           $time, oldest.found, actual.found);
                  mismatches++;
               end
               if (actual.value !== oldest.value) begin
                  $display("%0t: read_value mismatch, expected %h, actual %h",
                           $time, oldest.value, actual.value);
                  mismatches++;
               end
               if (actual.evicted !== oldest.evicted) begin
                  $display("%0t: evicted mismatch, expected %0b, actual %0b",
                           $time, oldest.evicted, actual.evicted);
                  mismatches++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : receiver
      int hold_left;
      bit held_off;
      int pattern_left;
      int pattern_mode;
      hold_left = 0;
      held_off = 1'b0;
      pattern_left = 0;
      pattern_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held_off && responses_seen >= 300) begin
            // Long hold-off so that the block backs up and stalls its input.
            held_off = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_mode = $urandom_range(0, 2);
               pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (pattern_mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= ($urandom_range(0, 1) == 1);
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   task automatic send_req(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] data, input logic typed,
                           input cache_resp_type typed_value);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {data, key};
      typed_check <= typed;
      typed_rsp <= typed_value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps [PHASES];
      logic [KEY_W-1:0] key_pool [POOL_SIZE];
      logic [CAP_W-1:0] cap;
      logic [KEY_W-1:0] key;
      int               pool_used;
      int               burst_left;
      int               gap;
      phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd9};
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CAPACITY) begin
            wait_drained(4);
            write_capacity(directed_rows[r].data[CSR_DATA_W-1:0]);
         end else begin
            send_req(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].data,
                     directed_rows[r].typed, directed_rows[r].resp);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         cap = (p == PHASES - 1) ? CAP_W'($urandom_range(2, 15)) : phase_caps[p];
         wait_drained(4);
         write_capacity({3'($urandom_range(0, 7)), cap});
         foreach (key_pool[k]) begin
            key_pool[k] = $urandom;
         end
         key_pool[0] = 32'h8000_0000;
         key_pool[1] = 32'h7FFF_FFFF;
         pool_used = $urandom_range(2, POOL_SIZE);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               if (gap > 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if ($urandom_range(0, 9) == 0) begin
               key = $urandom;
            end else begin
               key = key_pool[$urandom_range(0, pool_used - 1)];
            end
            send_req($urandom_range(0, 1) == 1 ? OP_PUT : OP_GET, key, $urandom, 1'b0, '0);
         end
      end

      wait_drained(30);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
